>>> rtl/swtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtl_pkg
// Types, constants and small helpers shared by the swing/twist limit fitter.
// ----------------------------------------------------------------------------
package swtl_pkg;

    // Field widths
    localparam int ANG_W   = 16;   // signed angle, 1/128 degree
    localparam int LIM_W   = 15;   // unsigned limit / config register
    localparam int Q_W     = 16;   // internal quaternion component
    localparam int MOP_W   = 33;   // multiplier operand
    localparam int PROD_W  = 64;   // registered product and swung-axis vector
    localparam int CX_W    = 34;   // CORDIC x / y
    localparam int Z_W     = 25;   // CORDIC angle, Q16 degrees
    localparam int STEP_W  = 5;
    localparam int CORDIC_STEPS = 23;

    // Angle unit: Q16 degrees rounded to the nearest 1/128 degree
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int DEGQ_BITS       = 16;
    localparam int UNIT_SHIFT      = DEGQ_BITS - ANGLE_FRAC_BITS;

    localparam logic signed [17:0] HALF_TURN = 18'sd23040;
    localparam logic signed [17:0] FULL_TURN = 18'sd46080;
    localparam logic signed [Z_W-1:0] QUARTER_Q16 = 25'sd5898240;
    localparam logic signed [Z_W-1:0] HALF_Q16    = 25'sd11796480;
    localparam logic [19:0] TWIST_RATIO = 20'd1000000;

    // Configuration register indexes
    localparam logic [1:0] REG_MARGIN     = 2'd0;
    localparam logic [1:0] REG_MIN_EXTENT = 2'd1;
    localparam logic [1:0] REG_MAX_EXTENT = 2'd2;
    localparam logic [LIM_W-1:0] MAX_EXTENT_RST = 15'd23040;

    // Multiplier operations; each names its operands
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_WW,
        MUL_XX,
        MUL_YY,
        MUL_ZZ,
        MUL_YW,
        MUL_ZX,
        MUL_ZW,
        MUL_XY,
        MUL_TWR,
        MUL_SWSW,
        MUL_SYSY,
        MUL_SZSZ,
        MUL_SWSZ,
        MUL_SWSY
    } mul_op_t;

    typedef enum logic [1:0] {
        ATAN_TWIST,
        ATAN_SWING_Y,
        ATAN_SWING_Z
    } atan_sel_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_PROD,
        C_RATIO,
        C_GAP,
        C_SETUP,
        C_VPROD,
        C_VGAP,
        C_ATAN,
        C_ATAN_WAIT,
        C_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        AT_IDLE,
        AT_NORM,
        AT_ITER
    } at_state_t;

    typedef struct packed {
        logic      load;
        mul_op_t   mul_op;
        logic      setup;
        logic      atan_start;
        logic      atan_cap;
        atan_sel_t atan_sel;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        logic twist_on;
        logic atan_done;
        logic out_busy;
    } dp_status_t;

    // CORDIC arc table, atan(2^-i) in Q16 degrees
    function automatic logic [21:0] arc_at(input logic [STEP_W-1:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

    // Fold first-quadrant angle into the quadrant of (x, y)
    function automatic logic signed [Z_W-1:0] at_adjust(
        input logic signed [Z_W-1:0] base,
        input logic                  xneg,
        input logic                  yneg
    );
        logic signed [Z_W-1:0] r;
        r = base;
        if (xneg)
            r = HALF_Q16 - r;
        if (yneg)
            r = -r;
        return r;
    endfunction

endpackage

>>> rtl/swtl_atan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtl_atan
// Iterative atan2: stepwise normalization, then a 23-step CORDIC in Q16 degrees.
// ----------------------------------------------------------------------------
module swtl_atan (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [swtl_pkg::PROD_W-1:0]   y_in,
    input  logic signed [swtl_pkg::PROD_W-1:0]   x_in,
    output logic                                 done,
    output logic signed [swtl_pkg::Z_W-1:0]      result
);
    import swtl_pkg::*;

    at_state_t state_reg, state_next;

    logic [PROD_W-1:0]        ax_reg, ay_reg, m;
    logic                     xneg_reg, yneg_reg;
    logic signed [CX_W-1:0]   cx_reg, cy_reg, dx, dy, cx_next, cy_next;
    logic signed [Z_W-1:0]    z_reg, z_next, arc;
    logic [STEP_W-1:0]        step_reg;
    logic signed [Z_W-1:0]    result_reg;
    logic                     done_reg;
    logic                     in_range;

    assign m        = ax_reg | ay_reg;
    assign in_range = (m == '0) || (~|m[PROD_W-1:30] && m[29]);

    assign dx  = cy_reg >>> step_reg;
    assign dy  = cx_reg >>> step_reg;
    assign arc = {3'b000, arc_at(step_reg)};

    always_comb
    begin
        if (!cy_reg[CX_W-1])
        begin
            cx_next = cx_reg + dx;
            cy_next = cy_reg - dy;
            z_next  = z_reg + arc;
        end
        else
        begin
            cx_next = cx_reg - dx;
            cy_next = cy_reg + dy;
            z_next  = z_reg - arc;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AT_IDLE:
            begin
                if (start)
                    state_next = AT_NORM;
            end
            AT_NORM:
            begin
                if (in_range && ay_reg != '0 && ax_reg != '0)
                    state_next = AT_ITER;
                else if (in_range)
                    state_next = AT_IDLE;
            end
            AT_ITER:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = AT_IDLE;
            end
            default: state_next = AT_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == AT_NORM && in_range && (ay_reg == '0 || ax_reg == '0))
                      || (state_reg == AT_ITER && step_reg == STEP_W'(CORDIC_STEPS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            AT_IDLE:
            begin
                if (start)
                begin
                    ax_reg   <= x_in[PROD_W-1] ? PROD_W'(-x_in) : PROD_W'(x_in);
                    ay_reg   <= y_in[PROD_W-1] ? PROD_W'(-y_in) : PROD_W'(y_in);
                    xneg_reg <= x_in[PROD_W-1];
                    yneg_reg <= y_in[PROD_W-1];
                end
            end
            AT_NORM:
            begin
                if (in_range)
                begin
                    cx_reg   <= $signed(ax_reg[CX_W-1:0]);
                    cy_reg   <= $signed(ay_reg[CX_W-1:0]);
                    z_reg    <= '0;
                    step_reg <= '0;
                    if (ay_reg == '0)
                        result_reg <= at_adjust('0, xneg_reg, yneg_reg);
                    else if (ax_reg == '0)
                        result_reg <= at_adjust(QUARTER_Q16, xneg_reg, yneg_reg);
                end
                else if (|m[PROD_W-1:37])
                begin
                    ax_reg <= ax_reg >> 8;
                    ay_reg <= ay_reg >> 8;
                end
                else if (|m[PROD_W-1:30])
                begin
                    ax_reg <= ax_reg >> 1;
                    ay_reg <= ay_reg >> 1;
                end
                else if (~|m[PROD_W-1:22])
                begin
                    ax_reg <= ax_reg << 8;
                    ay_reg <= ay_reg << 8;
                end
                else
                begin
                    ax_reg <= ax_reg << 1;
                    ay_reg <= ay_reg << 1;
                end
            end
            AT_ITER:
            begin
                cx_reg   <= cx_next;
                cy_reg   <= cy_next;
                z_reg    <= z_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    result_reg <= at_adjust(z_next, xneg_reg, yneg_reg);
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/swtl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtl_ctrl
// Sequencer: products, twist test, swing vector, two or three atan2 runs, write-out.
// ----------------------------------------------------------------------------
module swtl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  swtl_pkg::dp_status_t   status,
    output swtl_pkg::dp_cmd_t      cmd
);
    import swtl_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    atan_sel_t   sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            sel_reg   <= ATAN_TWIST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.mul_op     = MUL_NONE;
        cmd.setup      = 1'b0;
        cmd.atan_start = 1'b0;
        cmd.atan_cap   = 1'b0;
        cmd.atan_sel   = sel_reg;
        cmd.finish     = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = C_PROD;
                end
            end
            C_PROD:
            begin
                case (step_reg)
                    3'd0:    cmd.mul_op = MUL_WW;
                    3'd1:    cmd.mul_op = MUL_XX;
                    3'd2:    cmd.mul_op = MUL_YY;
                    3'd3:    cmd.mul_op = MUL_ZZ;
                    3'd4:    cmd.mul_op = MUL_YW;
                    3'd5:    cmd.mul_op = MUL_ZX;
                    3'd6:    cmd.mul_op = MUL_ZW;
                    default: cmd.mul_op = MUL_XY;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7)
                    state_next = C_RATIO;
            end
            C_RATIO:
            begin
                cmd.mul_op = MUL_TWR;
                state_next = C_GAP;
            end
            C_GAP:
                state_next = C_SETUP;
            C_SETUP:
            begin
                cmd.setup = 1'b1;
                step_next = '0;
                if (status.twist_on)
                begin
                    sel_next   = ATAN_TWIST;
                    state_next = C_VPROD;
                end
                else
                begin
                    sel_next   = ATAN_SWING_Y;
                    state_next = C_ATAN;
                end
            end
            C_VPROD:
            begin
                case (step_reg)
                    3'd0:    cmd.mul_op = MUL_SWSW;
                    3'd1:    cmd.mul_op = MUL_SYSY;
                    3'd2:    cmd.mul_op = MUL_SZSZ;
                    3'd3:    cmd.mul_op = MUL_SWSZ;
                    default: cmd.mul_op = MUL_SWSY;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd4)
                    state_next = C_VGAP;
            end
            C_VGAP:
                state_next = C_ATAN;
            C_ATAN:
            begin
                cmd.atan_start = 1'b1;
                state_next     = C_ATAN_WAIT;
            end
            C_ATAN_WAIT:
            begin
                if (status.atan_done)
                begin
                    cmd.atan_cap = 1'b1;
                    case (sel_reg)
                        ATAN_TWIST:
                        begin
                            sel_next   = ATAN_SWING_Y;
                            state_next = C_ATAN;
                        end
                        ATAN_SWING_Y:
                        begin
                            sel_next   = ATAN_SWING_Z;
                            state_next = C_ATAN;
                        end
                        default: state_next = C_FINISH;
                    endcase
                end
            end
            C_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

endmodule

>>> rtl/swtl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtl_datapath
// Shared multiplier with accumulators, atan2 unit, limit tracking, result register.
// ----------------------------------------------------------------------------
module swtl_datapath #(
    parameter int QUAT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swtl_pkg::dp_cmd_t                   cmd,
    output swtl_pkg::dp_status_t                status,
    input  logic [QUAT_BITS-1:0]                quat_w,
    input  logic [QUAT_BITS-1:0]                quat_x,
    input  logic [QUAT_BITS-1:0]                quat_y,
    input  logic [QUAT_BITS-1:0]                quat_z,
    input  logic                                last_sample,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [swtl_pkg::LIM_W-1:0]          cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [swtl_pkg::ANG_W-1:0]   twist_angle,
    output logic signed [swtl_pkg::ANG_W-1:0]   swing_y_angle,
    output logic signed [swtl_pkg::ANG_W-1:0]   swing_z_angle,
    output logic                                limits_valid,
    output logic [swtl_pkg::LIM_W-1:0]          swing_y_limit,
    output logic [swtl_pkg::LIM_W-1:0]          swing_z_limit,
    output logic signed [swtl_pkg::ANG_W-1:0]   twist_lower_limit,
    output logic [swtl_pkg::LIM_W-1:0]          twist_upper_limit
);
    import swtl_pkg::*;

    // Bring components to 16 bits
    logic signed [Q_W-1:0] w16, x16, y16, z16;
    generate
        if (QUAT_BITS >= Q_W)
        begin : g_narrow
            assign w16 = quat_w[QUAT_BITS-1 -: Q_W];
            assign x16 = quat_x[QUAT_BITS-1 -: Q_W];
            assign y16 = quat_y[QUAT_BITS-1 -: Q_W];
            assign z16 = quat_z[QUAT_BITS-1 -: Q_W];
        end
        else
        begin : g_widen
            assign w16 = {quat_w, {(Q_W-QUAT_BITS){1'b0}}};
            assign x16 = {quat_x, {(Q_W-QUAT_BITS){1'b0}}};
            assign y16 = {quat_y, {(Q_W-QUAT_BITS){1'b0}}};
            assign z16 = {quat_z, {(Q_W-QUAT_BITS){1'b0}}};
        end
    endgenerate

    logic signed [Q_W-1:0]      w_reg, x_reg, y_reg, z_reg;
    logic                       last_reg;
    logic signed [MOP_W-1:0]    tw2_reg, yz_reg, s1_reg, s2_reg;
    logic signed [31:0]         sw_reg, sy_reg, sz_reg;
    logic signed [PROD_W-1:0]   vx_reg, vy_reg, vz_reg, prod_reg;
    mul_op_t                    op_reg;
    logic                       twist_on_reg;
    logic signed [ANG_W-1:0]    tw_ang_reg, sy_ang_reg, sz_ang_reg;

    logic [LIM_W-1:0]           margin_reg, min_ext_reg, max_ext_reg;
    logic [LIM_W-1:0]           peak_y_reg, peak_z_reg;
    logic signed [ANG_W-1:0]    low_reg, high_reg;
    logic                       out_valid_reg;

    // Multiplier operand selection
    logic signed [MOP_W-1:0]    mul_a, mul_b;
    logic signed [2*MOP_W-1:0]  mul_full;

    function automatic logic signed [MOP_W-1:0] ext16(input logic signed [Q_W-1:0] v);
        return {{(MOP_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic logic signed [MOP_W-1:0] ext32(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    always_comb
    begin
        case (cmd.mul_op)
            MUL_WW:   begin mul_a = ext16(w_reg);  mul_b = ext16(w_reg); end
            MUL_XX:   begin mul_a = ext16(x_reg);  mul_b = ext16(x_reg); end
            MUL_YY:   begin mul_a = ext16(y_reg);  mul_b = ext16(y_reg); end
            MUL_ZZ:   begin mul_a = ext16(z_reg);  mul_b = ext16(z_reg); end
            MUL_YW:   begin mul_a = ext16(y_reg);  mul_b = ext16(w_reg); end
            MUL_ZX:   begin mul_a = ext16(z_reg);  mul_b = ext16(x_reg); end
            MUL_ZW:   begin mul_a = ext16(z_reg);  mul_b = ext16(w_reg); end
            MUL_XY:   begin mul_a = ext16(x_reg);  mul_b = ext16(y_reg); end
            MUL_TWR:  begin mul_a = tw2_reg; mul_b = $signed({13'b0, TWIST_RATIO}); end
            MUL_SWSW: begin mul_a = ext32(sw_reg); mul_b = ext32(sw_reg); end
            MUL_SYSY: begin mul_a = ext32(sy_reg); mul_b = ext32(sy_reg); end
            MUL_SZSZ: begin mul_a = ext32(sz_reg); mul_b = ext32(sz_reg); end
            MUL_SWSZ: begin mul_a = ext32(sw_reg); mul_b = ext32(sz_reg); end
            MUL_SWSY: begin mul_a = ext32(sw_reg); mul_b = ext32(sy_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    logic signed [PROD_W-1:0] n2_ext;
    assign n2_ext = PROD_W'($signed({tw2_reg[MOP_W-1], tw2_reg}) + $signed({yz_reg[MOP_W-1], yz_reg}));

    // atan2 unit
    logic signed [PROD_W-1:0] at_y, at_x;
    logic                     at_done;
    logic signed [Z_W-1:0]    at_res;

    always_comb
    begin
        case (cmd.atan_sel)
            ATAN_TWIST:
            begin
                at_y = {{(PROD_W-Q_W){x_reg[Q_W-1]}}, x_reg};
                at_x = {{(PROD_W-Q_W){w_reg[Q_W-1]}}, w_reg};
            end
            ATAN_SWING_Y:
            begin
                at_y = vy_reg;
                at_x = vx_reg;
            end
            default:
            begin
                at_y = vz_reg;
                at_x = vx_reg;
            end
        endcase
    end

    swtl_atan u_atan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.atan_start),
        .y_in   (at_y),
        .x_in   (at_x),
        .done   (at_done),
        .result (at_res)
    );

    // Angle rounding to output units
    logic signed [26:0]       tw_sum;
    logic signed [17:0]       tw_units, tw_wrap;
    logic signed [25:0]       sw_sum;

    assign tw_sum   = ({{2{at_res[Z_W-1]}}, at_res} <<< 1) + 27'sd256;
    assign tw_units = tw_sum[26:UNIT_SHIFT];
    assign sw_sum   = {at_res[Z_W-1], at_res} + 26'sd256;

    always_comb
    begin
        if (tw_units > HALF_TURN)
            tw_wrap = tw_units - FULL_TURN;
        else if (tw_units < -HALF_TURN)
            tw_wrap = tw_units + FULL_TURN;
        else
            tw_wrap = tw_units;
    end

    // Limit tracking and fit
    logic signed [ANG_W-1:0] abs_y, abs_z;
    logic [LIM_W-1:0]        peak_y_new, peak_z_new;
    logic signed [ANG_W-1:0] low_new, high_new;
    logic [LIM_W-1:0]        lim_y, lim_z, lim_up;
    logic signed [17:0]      lo_v;
    logic signed [ANG_W-1:0] lim_lo;

    function automatic logic [LIM_W-1:0] clamp_u(
        input logic [LIM_W+1:0] v,
        input logic [LIM_W-1:0] lo,
        input logic [LIM_W-1:0] hi
    );
        logic [LIM_W+1:0] r;
        r = v;
        if (r < {2'b00, lo})
            r = {2'b00, lo};
        if (r > {2'b00, hi})
            r = {2'b00, hi};
        return r[LIM_W-1:0];
    endfunction

    assign abs_y = sy_ang_reg[ANG_W-1] ? -sy_ang_reg : sy_ang_reg;
    assign abs_z = sz_ang_reg[ANG_W-1] ? -sz_ang_reg : sz_ang_reg;
    assign peak_y_new = (abs_y[LIM_W-1:0] > peak_y_reg) ? abs_y[LIM_W-1:0] : peak_y_reg;
    assign peak_z_new = (abs_z[LIM_W-1:0] > peak_z_reg) ? abs_z[LIM_W-1:0] : peak_z_reg;
    assign low_new    = (tw_ang_reg < low_reg)  ? tw_ang_reg : low_reg;
    assign high_new   = (tw_ang_reg > high_reg) ? tw_ang_reg : high_reg;

    assign lim_y  = clamp_u({2'b00, peak_y_new} + {2'b00, margin_reg}, min_ext_reg, max_ext_reg);
    assign lim_z  = clamp_u({2'b00, peak_z_new} + {2'b00, margin_reg}, min_ext_reg, max_ext_reg);

    logic signed [17:0] hi_v;
    assign hi_v   = {{2{high_new[ANG_W-1]}}, high_new} + $signed({3'b000, margin_reg});

    always_comb
    begin
        logic signed [17:0] r;
        r = hi_v;
        if (r < $signed({3'b000, min_ext_reg}))
            r = $signed({3'b000, min_ext_reg});
        if (r > $signed({3'b000, max_ext_reg}))
            r = $signed({3'b000, max_ext_reg});
        lim_up = r[LIM_W-1:0];
    end

    always_comb
    begin
        lo_v = {{2{low_new[ANG_W-1]}}, low_new} - $signed({3'b000, margin_reg});
        if (lo_v < -$signed({3'b000, max_ext_reg}))
            lo_v = -$signed({3'b000, max_ext_reg});
        if (lo_v > -$signed({3'b000, min_ext_reg}))
            lo_v = -$signed({3'b000, min_ext_reg});
        lim_lo = lo_v[ANG_W-1:0];
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= MUL_NONE;
            margin_reg    <= '0;
            min_ext_reg   <= '0;
            max_ext_reg   <= MAX_EXTENT_RST;
            peak_y_reg    <= '0;
            peak_z_reg    <= '0;
            low_reg       <= HALF_TURN[ANG_W-1:0];
            high_reg      <= -HALF_TURN[ANG_W-1:0];
            out_valid_reg <= 1'b0;
            twist_on_reg  <= 1'b0;
        end
        else
        begin
            op_reg <= cmd.mul_op;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MARGIN:     margin_reg  <= cfg_data;
                    REG_MIN_EXTENT: min_ext_reg <= cfg_data;
                    REG_MAX_EXTENT: max_ext_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (op_reg == MUL_TWR)
                twist_on_reg <= prod_reg > n2_ext;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    peak_y_reg <= '0;
                    peak_z_reg <= '0;
                    low_reg    <= HALF_TURN[ANG_W-1:0];
                    high_reg   <= -HALF_TURN[ANG_W-1:0];
                end
                else
                begin
                    peak_y_reg <= peak_y_new;
                    peak_z_reg <= peak_z_new;
                    low_reg    <= low_new;
                    high_reg   <= high_new;
                end
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[PROD_W-1:0];
        if (cmd.load)
        begin
            w_reg      <= w16;
            x_reg      <= x16;
            y_reg      <= y16;
            z_reg      <= z16;
            last_reg   <= last_sample;
            tw2_reg    <= '0;
            yz_reg     <= '0;
            s1_reg     <= '0;
            s2_reg     <= '0;
            tw_ang_reg <= '0;
        end
        else
        begin
            case (op_reg)
                MUL_WW, MUL_XX: tw2_reg <= tw2_reg + prod_reg[MOP_W-1:0];
                MUL_YY, MUL_ZZ: yz_reg  <= yz_reg + prod_reg[MOP_W-1:0];
                MUL_YW:         s1_reg  <= s1_reg + prod_reg[MOP_W-1:0];
                MUL_ZX:         s1_reg  <= s1_reg - prod_reg[MOP_W-1:0];
                MUL_ZW, MUL_XY: s2_reg  <= s2_reg + prod_reg[MOP_W-1:0];
                MUL_SWSW:       vx_reg  <= vx_reg + prod_reg;
                MUL_SYSY, MUL_SZSZ: vx_reg <= vx_reg - prod_reg;
                MUL_SWSZ:       vy_reg  <= vy_reg + (prod_reg <<< 1);
                MUL_SWSY:       vz_reg  <= vz_reg - (prod_reg <<< 1);
                default: ;
            endcase
        end
        if (cmd.setup)
        begin
            if (twist_on_reg)
            begin
                sw_reg <= tw2_reg[32:1];
                sy_reg <= 32'((s1_reg + $signed({32'b0, s1_reg[MOP_W-1]})) >>> 1);
                sz_reg <= 32'((s2_reg + $signed({32'b0, s2_reg[MOP_W-1]})) >>> 1);
                vx_reg <= '0;
                vy_reg <= '0;
                vz_reg <= '0;
            end
            else
            begin
                vx_reg <= PROD_W'(tw2_reg - yz_reg);
                vy_reg <= PROD_W'(s2_reg) <<< 1;
                vz_reg <= -(PROD_W'(s1_reg) <<< 1);
            end
        end
        if (cmd.atan_cap)
        begin
            case (cmd.atan_sel)
                ATAN_TWIST:   tw_ang_reg <= tw_wrap[ANG_W-1:0];
                ATAN_SWING_Y: sy_ang_reg <= sw_sum[ANG_W+UNIT_SHIFT-1:UNIT_SHIFT];
                default:      sz_ang_reg <= sw_sum[ANG_W+UNIT_SHIFT-1:UNIT_SHIFT];
            endcase
        end
        if (cmd.finish)
        begin
            twist_angle       <= tw_ang_reg;
            swing_y_angle     <= sy_ang_reg;
            swing_z_angle     <= sz_ang_reg;
            limits_valid      <= last_reg;
            swing_y_limit     <= last_reg ? lim_y  : '0;
            swing_z_limit     <= last_reg ? lim_z  : '0;
            twist_lower_limit <= last_reg ? lim_lo : '0;
            twist_upper_limit <= last_reg ? lim_up : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status.twist_on  = twist_on_reg;
    assign status.atan_done = at_done;
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

>>> rtl/swing_twist_limit_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swing_twist_limit_fit
// Swing/twist split of rotation quaternions with joint-limit fitting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one quaternion (quat_w..quat_z,
//   Q1.15) and last_sample per transaction. Output channel (out_valid/
//   out_ready) returns one transaction per input: the twist and both swing
//   angles in 1/128 degree, and on the last sample of a set the fitted limits
//   (limits_valid high), after which the tracked extremes are cleared.
//   Configuration: cfg_we writes cfg_data to register cfg_index (0 margin,
//   1 min extent, 2 max extent); write only while the block is idle.
//   Products are formed on the shared multiplier, with a second set of
//   products when the twist is taken. Each atan2 run first normalizes its
//   operands by shifts, then runs the CORDIC unless an operand is zero; it
//   runs three times, twice when the twist is degenerate, and a write-out
//   of the result follows.
//   One transaction is processed at a time; in_ready is high only when the
//   sequencer is idle. The result sits in an output register, so the next
//   transaction is accepted while it waits; a stalled receiver holds the
//   sequencer at write-out of the following result.
//   Reset clears the sequencer, the tracked extremes and the configuration
//   registers to their defaults.
// ----------------------------------------------------------------------------
module swing_twist_limit_fit #(
    parameter int QUAT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [QUAT_BITS-1:0]                quat_w,
    input  logic [QUAT_BITS-1:0]                quat_x,
    input  logic [QUAT_BITS-1:0]                quat_y,
    input  logic [QUAT_BITS-1:0]                quat_z,
    input  logic                                last_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [swtl_pkg::ANG_W-1:0]   twist_angle,
    output logic signed [swtl_pkg::ANG_W-1:0]   swing_y_angle,
    output logic signed [swtl_pkg::ANG_W-1:0]   swing_z_angle,
    output logic                                limits_valid,
    output logic [swtl_pkg::LIM_W-1:0]          swing_y_limit,
    output logic [swtl_pkg::LIM_W-1:0]          swing_z_limit,
    output logic signed [swtl_pkg::ANG_W-1:0]   twist_lower_limit,
    output logic [swtl_pkg::LIM_W-1:0]          twist_upper_limit,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [swtl_pkg::LIM_W-1:0]          cfg_data
);
    import swtl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: drive one transaction through the datapath
    swtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: products, atan2, extreme tracking, result register
    swtl_datapath #(
        .QUAT_BITS (QUAT_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .quat_w            (quat_w),
        .quat_x            (quat_x),
        .quat_y            (quat_y),
        .quat_z            (quat_z),
        .last_sample       (last_sample),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .twist_angle       (twist_angle),
        .swing_y_angle     (swing_y_angle),
        .swing_z_angle     (swing_z_angle),
        .limits_valid      (limits_valid),
        .swing_y_limit     (swing_y_limit),
        .swing_z_limit     (swing_z_limit),
        .twist_lower_limit (twist_lower_limit),
        .twist_upper_limit (twist_upper_limit)
    );

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid && !out_ready))
        else $error("result register overwritten while stalled");

    // One transaction in flight: no accept right after an accept
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction accepted while busy");

    // Limit fields are zero on non-final results
    a_limits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !limits_valid) |-> (swing_y_limit == '0 && swing_z_limit == '0
            && twist_lower_limit == '0 && twist_upper_limit == '0))
        else $error("limit fields nonzero without limits_valid");

    // Fitted lower twist bound is never positive
    a_lower_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && limits_valid) |-> (twist_lower_limit[ANG_W-1] || twist_lower_limit == '0))
        else $error("positive lower twist limit");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swing/twist limit fitter testbench
// Drives quaternion transactions into swing_twist_limit_fit with random
// gaps and output stalls, predicts every result with a bit-exact model of
// the swing/twist split and limit fit, and compares each output transaction
// field by field. Runs several limit configurations, extremes included.
// ----------------------------------------------------------------------------
module testbench;
    import swtl_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;  // unmapped index, must be ignored
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;

    // One predicted output transaction
    typedef struct {
        logic signed [ANG_W-1:0] twist;
        logic signed [ANG_W-1:0] sy;
        logic signed [ANG_W-1:0] sz;
        logic                    lv;
        logic [LIM_W-1:0]        y_lim;
        logic [LIM_W-1:0]        z_lim;
        logic signed [ANG_W-1:0] tw_lo;
        logic [LIM_W-1:0]        tw_hi;
    } angles_t;

    // ------------------------------------------------------------------------
    // Limit-fit scoreboard: own copy of the registers and tracked extremes
    // ------------------------------------------------------------------------
    class limit_fit_board;
        longint margin_r, min_ext, max_ext;
        longint peak_y, peak_z, low_tw, high_tw;
        angles_t pending_q[$];
        int errors;
        int checked;
        int fits;
        longint arcs[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
            117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1};

        function void clear_extremes();
            peak_y  = 0;
            peak_z  = 0;
            low_tw  = 23040;
            high_tw = -23040;
        endfunction

        function void reset_regs();
            margin_r = 0;
            min_ext  = 0;
            max_ext  = MAX_EXTENT_RST;
            clear_extremes();
            errors  = 0;
            checked = 0;
            fits    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [LIM_W-1:0] val);
            case (idx)
                REG_MARGIN:     margin_r = val;
                REG_MIN_EXTENT: min_ext  = val;
                REG_MAX_EXTENT: max_ext  = val;
                default: ;
            endcase
        endfunction

        // atan2 in Q16 degrees, range -180 to +180
        function longint atan2_deg(longint y, longint x);
            longint unsigned ax, ay, m;
            longint base, cx, cy, acc, dx, dy;
            ax = (x < 0) ? longint'(-x) : x;
            ay = (y < 0) ? longint'(-y) : y;
            m = ax | ay;
            while (m >= (64'd1 << 30))
            begin
                ax >>= 1; ay >>= 1; m >>= 1;
            end
            while (m != 0 && m < (64'd1 << 29))
            begin
                ax <<= 1; ay <<= 1; m <<= 1;
            end
            if (ay == 0)
                base = 0;
            else if (ax == 0)
                base = longint'(90) << 16;
            else
            begin
                cx = ax;
                cy = ay;
                acc = 0;
                for (int i = 0; i < CORDIC_STEPS; i++)
                begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy >= 0)
                    begin
                        cx += dx; cy -= dy; acc += arcs[i];
                    end
                    else
                    begin
                        cx -= dx; cy += dy; acc -= arcs[i];
                    end
                end
                base = acc;
            end
            if (x < 0)
                base = (longint'(180) << 16) - base;
            if (y < 0)
                base = -base;
            return base;
        endfunction

        function longint to_units(longint q16);
            return (q16 + (longint'(1) << (UNIT_SHIFT - 1))) >>> UNIT_SHIFT;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            return v;
        endfunction

        // Predict the result of one accepted quaternion
        function void note_input(logic signed [15:0] qw, logic signed [15:0] qx,
                                 logic signed [15:0] qy, logic signed [15:0] qz,
                                 logic last);
            longint w, x, y, z, tw2, n2, tw, vx, vy, vz, ay_, az_, sw, s_y, s_z;
            angles_t e;
            w = qw; x = qx; y = qy; z = qz;
            tw2 = w * w + x * x;
            n2 = tw2 + y * y + z * z;
            tw = 0;
            if (tw2 * 1000000 > n2)
            begin
                sw  = tw2 / 2;
                s_y = (y * w - z * x) / 2;
                s_z = (z * w + x * y) / 2;
                tw = to_units(2 * atan2_deg(x, w));
                if (tw > 23040) tw -= 46080;
                else if (tw < -23040) tw += 46080;
                vx = sw * sw - s_y * s_y - s_z * s_z;
                vy = 2 * sw * s_z;
                vz = -2 * sw * s_y;
            end
            else
            begin
                vx = w * w + x * x - y * y - z * z;
                vy = 2 * (x * y + w * z);
                vz = 2 * (x * z - w * y);
            end
            ay_ = to_units(atan2_deg(vy, vx));
            az_ = to_units(atan2_deg(vz, vx));
            if ((ay_ < 0 ? -ay_ : ay_) > peak_y) peak_y = ay_ < 0 ? -ay_ : ay_;
            if ((az_ < 0 ? -az_ : az_) > peak_z) peak_z = az_ < 0 ? -az_ : az_;
            if (tw < low_tw) low_tw = tw;
            if (tw > high_tw) high_tw = tw;
            e.twist = tw;
            e.sy = ay_;
            e.sz = az_;
            e.lv = last;
            e.y_lim = '0; e.z_lim = '0; e.tw_lo = '0; e.tw_hi = '0;
            if (last)
            begin
                e.y_lim = clamp(peak_y + margin_r, min_ext, max_ext);
                e.z_lim = clamp(peak_z + margin_r, min_ext, max_ext);
                e.tw_lo = clamp(low_tw - margin_r, -max_ext, -min_ext);
                e.tw_hi = clamp(high_tw + margin_r, min_ext, max_ext);
                clear_extremes();
            end
            pending_q = {pending_q, e};
        endfunction

        function void report(string fld, longint want, longint got);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, fld, want, got);
            errors++;
        endfunction

        // Compare one output transaction with the oldest prediction
        function void check_result(angles_t got);
            angles_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t ns: output transaction with nothing expected", $time);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (e.lv) fits++;
            if (got.twist !== e.twist) report("twist_angle", e.twist, got.twist);
            if (got.sy !== e.sy) report("swing_y_angle", e.sy, got.sy);
            if (got.sz !== e.sz) report("swing_z_angle", e.sz, got.sz);
            if (got.lv !== e.lv) report("limits_valid", e.lv, got.lv);
            if (got.y_lim !== e.y_lim) report("swing_y_limit", e.y_lim, got.y_lim);
            if (got.z_lim !== e.z_lim) report("swing_z_limit", e.z_lim, got.z_lim);
            if (got.tw_lo !== e.tw_lo)
                report("twist_lower_limit", e.tw_lo, got.tw_lo);
            if (got.tw_hi !== e.tw_hi)
                report("twist_upper_limit", e.tw_hi, got.tw_hi);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic last_sample = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [ANG_W-1:0] twist_angle, swing_y_angle, swing_z_angle;
    logic limits_valid;
    logic [LIM_W-1:0] swing_y_limit, swing_z_limit, twist_upper_limit;
    logic signed [ANG_W-1:0] twist_lower_limit;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [LIM_W-1:0] cfg_data = '0;

    limit_fit_board board = new();
    bit tx_gaps = 1'b0;     // sender may idle between transactions
    bit rx_stalls = 1'b0;   // receiver may stall
    bit long_hold = 1'b0;   // one long receiver hold-off requested
    int accepted_in = 0;
    int idle_cycles = 0;

    always #6 clk = ~clk;

    swing_twist_limit_fit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .quat_w            (quat_w),
        .quat_x            (quat_x),
        .quat_y            (quat_y),
        .quat_z            (quat_z),
        .last_sample       (last_sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .twist_angle       (twist_angle),
        .swing_y_angle     (swing_y_angle),
        .swing_z_angle     (swing_z_angle),
        .limits_valid      (limits_valid),
        .swing_y_limit     (swing_y_limit),
        .swing_z_limit     (swing_z_limit),
        .twist_lower_limit (twist_lower_limit),
        .twist_upper_limit (twist_upper_limit),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Monitor the input channel: predict on every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            board.note_input(quat_w, quat_x, quat_y, quat_z, last_sample);
            accepted_in++;
        end
    end

    // Monitor the output channel: check every accepted transaction
    always @(posedge clk)
    begin
        angles_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.twist = twist_angle;
            got.sy    = swing_y_angle;
            got.sz    = swing_z_angle;
            got.lv    = limits_valid;
            got.y_lim = swing_y_limit;
            got.z_lim = swing_z_limit;
            got.tw_lo = twist_lower_limit;
            got.tw_hi = twist_upper_limit;
            board.check_result(got);
        end
    end

    // Watchdog: count cycles with no transaction on either channel or config port
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: watchdog expired, %0d results still expected",
                     $time, board.pending_q.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one quaternion and hold it until the handshake completes
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic last);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        quat_w      <= w;
        quat_x      <= x;
        quat_y      <= y;
        quat_z      <= z;
        last_sample <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait until every predicted result has been checked
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [LIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic set_limits(logic [LIM_W-1:0] mg, logic [LIM_W-1:0] lo,
                              logic [LIM_W-1:0] hi);
        write_cfg(REG_MARGIN, mg);
        write_cfg(REG_MIN_EXTENT, lo);
        write_cfg(REG_MAX_EXTENT, hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random quaternion of a chosen flavor
    task automatic rand_quat(output logic [15:0] w, output logic [15:0] x,
                             output logic [15:0] y, output logic [15:0] z);
        int kind;
        kind = $urandom_range(0, 9);
        w = $urandom; x = $urandom; y = $urandom; z = $urandom;
        case (kind)
            0:       // degenerate twist: w and x tiny against y, z
            begin
                w = $urandom_range(0, 10) - 5;
                x = $urandom_range(0, 10) - 5;
            end
            1:       // large scalar part, small y and z
            begin
                w = $urandom_range(28000, 32767);
                y = $urandom_range(0, 4000) - 2000;
                z = $urandom_range(0, 4000) - 2000;
            end
            2:       // tiny magnitudes, exercise normalization upward
            begin
                w = $urandom_range(0, 6) - 3; x = $urandom_range(0, 6) - 3;
                y = $urandom_range(0, 6) - 3; z = $urandom_range(0, 6) - 3;
            end
            3:       // pure twist about X
            begin
                y = 16'd0; z = 16'd0;
            end
            4:       // negative scalar part, wraps the doubled twist
            begin
                w = -$urandom_range(1, 32768);
            end
            default: ;
        endcase
    endtask

    // Send one sample set of random quaternions
    task automatic send_set(int len);
        logic [15:0] w, x, y, z;
        for (int i = 0; i < len; i++)
        begin
            rand_quat(w, x, y, z);
            send_quat(w, x, y, z, i == len - 1);
        end
    endtask

    initial
    begin
        int sets;
        board.reset_regs();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extremes, zero vector, pure twist, wrap and degenerate cases
        send_quat(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_quat(16'sd32767, 16'd0, 16'd0, 16'd0, 1'b0);
        send_quat(-16'sd32768, 16'd0, 16'd0, 16'd0, 1'b0);
        send_quat(16'd0, 16'sd32767, 16'd0, 16'd0, 1'b0);
        send_quat(16'd0, -16'sd32768, 16'd0, 16'd0, 1'b1);
        send_quat(16'd0, 16'd0, 16'sd32767, 16'd0, 1'b0);
        send_quat(16'd0, 16'd0, 16'd0, -16'sd32768, 1'b0);
        send_quat(16'd0, 16'd0, -16'sd32768, 16'sd32767, 1'b1);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        send_quat(-16'sd30000, 16'sd10000, 16'd0, 16'd0, 1'b0);
        send_quat(-16'sd30000, -16'sd10000, 16'd0, 16'd0, 1'b1);
        send_quat(16'sd23170, 16'sd23170, 16'd0, 16'd0, 1'b0);
        send_quat(16'sd1, 16'd0, 16'd0, 16'd0, 1'b0);
        send_quat(16'sd1, 16'd0, 16'sd30000, 16'd0, 1'b0);
        send_quat(16'd0, 16'sd1, 16'd0, 16'sd30000, 1'b1);
        send_quat(16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 1'b0);
        send_quat(16'sd2, -16'sd1, 16'sd3, -16'sd2, 1'b1);
        drain();

        // Random phases over several limit settings, extremes among them
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        sets = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_limits(15'd0, 15'd0, 15'd23040);
                1: set_limits(15'd23040, 15'd23040, 15'd23040);
                2: set_limits(15'd256, 15'd1280, 15'd15360);
                3: set_limits(15'd500, 15'd12000, 15'd3000);  // min above max
                4:
                begin
                    write_cfg(REG_UNUSED, 15'h7FFF);          // ignored index
                    set_limits($urandom_range(0, 23040), $urandom_range(0, 11520),
                               $urandom_range(11520, 23040));
                end
                default: set_limits(15'h7FFF & $urandom_range(0, 2000), 15'd0,
                                    15'd23040);
            endcase
            if (ph == 5)
            begin
                // final stretch runs with no idling on either side
                tx_gaps = 1'b0;
                rx_stalls = 1'b0;
            end
            if (ph == 2)
            begin
                // long receiver hold-off while the sender keeps offering
                long_hold = 1'b1;
                tx_gaps = 1'b0;
                send_set(12);
                tx_gaps = 1'b1;
                sets++;
            end
            for (int k = 0; k < 16; k++)
            begin
                send_set($urandom_range(1, 12));
                sets++;
                if (ph == 3 && k == 6)
                begin
                    // sender pause until everything outstanding has come back
                    in_valid <= 1'b0;
                    do @(posedge clk); while (board.pending_q.size() != 0);
                end
            end
            drain();
        end

        repeat (150) @(posedge clk);
        $display("Covered %0d quaternions in %0d random sets over 6 limit settings;",
                 accepted_in, sets);
        $display("%0d results checked, %0d of them carried fitted limits.",
                 board.checked, board.fits);
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
